[rtl/lgs_pkg.sv]
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int CfgW       = 10;
  localparam int CfgIdxW    = 2;
  localparam int PosW       = 9;
  localparam int MinSize    = 3;
  localparam int DefMaxWidth  = 512;
  localparam int DefMaxHeight = 512;

  localparam logic [CfgW-1:0] GridWidthRst  = CfgW'(400);
  localparam logic [CfgW-1:0] GridHeightRst = CfgW'(300);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_e;

endpackage

[rtl/lgs_row_mem.sv]
`timescale 1ns / 1ps

module lgs_row_mem #(
  parameter int Depth = 512,
  parameter int AddrW = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [1:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i,
  output logic             busy_o
);

  localparam int CntW = $clog2(Depth + 1);

  logic [1:0]      mem [Depth];
  logic [1:0]      rd_q;
  logic            fwd_q;
  logic [1:0]      fwd_data_q;
  logic [CntW-1:0] clr_cnt_q;
  logic            clearing;
  logic            we;
  logic [AddrW-1:0] waddr;
  logic [1:0]      wdata;

  // After reset every entry is swept to dead before the first request.
  assign clearing = (clr_cnt_q != CntW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + CntW'(1);
    end
  end

  assign we    = clearing || wr_en_i;
  assign waddr = clearing ? clr_cnt_q[AddrW-1:0] : wr_addr_i;
  assign wdata = clearing ? 2'b00 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // A read that meets a write to the same entry takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;
  assign busy_o    = clearing;

endmodule

[rtl/life_generation_stencil.sv]
`timescale 1ns / 1ps

// Channel  Signals                                       Direction
// in       in_valid_i in_ready_o cell_alive_i frame_start_i   request in
// out      out_valid_o out_ready_i next_alive_o out_row_o
//          out_col_o frame_end_o                          result out
// cfg      cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i     register write
//
// One cell per cycle unless stalled; a result goes through s1 and then the output register.
// The row stores share one memory, read on acceptance, written back from s1.
// After reset all MAX_WIDTH memory entries are cleared, during which in_ready_o is low.
// An output register and a holding stage let a new request enter while a result waits.

module life_generation_stencil #(
  parameter int MAX_WIDTH  = lgs_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = lgs_pkg::DefMaxHeight
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cell_alive_i,
  input  logic                       frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       next_alive_o,
  output logic [lgs_pkg::PosW-1:0]   out_row_o,
  output logic [lgs_pkg::PosW-1:0]   out_col_o,
  output logic                       frame_end_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lgs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lgs_pkg::CfgW-1:0]   cfg_data_i
);

  import lgs_pkg::*;

  localparam int CPW = $clog2(MAX_WIDTH);
  localparam int RPW = $clog2(MAX_HEIGHT);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int RCW = $clog2(MAX_HEIGHT + 1);
  localparam int WXW = (WCW > CfgW) ? WCW : CfgW;
  localparam int HXW = (RCW > CfgW) ? RCW : CfgW;

  logic [CfgW-1:0] grid_width_q, grid_height_q;
  logic [CPW-1:0]  col_pos_q;
  logic [RPW-1:0]  row_pos_q;

  logic            s1_valid_q, s1_cell_q, s1_border_q, s1_fend_q;
  logic [CPW-1:0]  s1_addr_q;
  logic [PosW-1:0] s1_qr_q, s1_qc_q;
  logic [8:0]      window_q;

  logic            out_valid_q, out_alive_q, out_fend_q;
  logic [PosW-1:0] out_row_q, out_col_q;

  logic            in_fire, s1_fire, mem_busy;
  logic [1:0]      rd_data;

  logic [WXW-1:0]  cfg_w_x;
  logic [HXW-1:0]  cfg_h_x;
  logic [WCW-1:0]  w, c, cn;
  logic [RCW-1:0]  h, r, rn, qr;
  logic [WCW-1:0]  qc;
  logic            border, fend;

  logic [8:0]      window_d;
  logic [3:0]      count;
  logic            alive;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridWidthRst;
      grid_height_q <= GridHeightRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_GRID_WIDTH) begin
        grid_width_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_GRID_HEIGHT) begin
        grid_height_q <= cfg_data_i;
      end
    end
  end

  assign cfg_w_x = WXW'(grid_width_q);
  assign cfg_h_x = HXW'(grid_height_q);
  assign w = (cfg_w_x < WXW'(MinSize)) ? WCW'(MinSize) :
             (cfg_w_x > WXW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(cfg_w_x);
  assign h = (cfg_h_x < HXW'(MinSize)) ? RCW'(MinSize) :
             (cfg_h_x > HXW'(MAX_HEIGHT)) ? RCW'(MAX_HEIGHT) : RCW'(cfg_h_x);

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !mem_busy && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic [WCW-1:0] c0;
    logic [RCW-1:0] r0;
    c0 = frame_start_i ? '0 : WCW'(col_pos_q);
    r0 = frame_start_i ? '0 : RCW'(row_pos_q);
    c  = c0;
    r  = r0;
    if (c0 >= w) begin
      c = '0;
      r = r0 + RCW'(1);
    end
    if (r >= h) begin
      r = '0;
    end

    if (c != '0) begin
      qc = c - WCW'(1);
      qr = (r != '0) ? r - RCW'(1) : h - RCW'(1);
    end else begin
      qc = w - WCW'(1);
      qr = (r >= RCW'(2)) ? r - RCW'(2) : r + h - RCW'(2);
    end

    border = (qr == '0) || (qr == h - RCW'(1)) || (qc == '0) || (qc == w - WCW'(1));
    fend   = (qr == h - RCW'(2)) && (qc == w - WCW'(2));

    cn = c + WCW'(1);
    rn = r;
    if (cn >= w) begin
      cn = '0;
      rn = r + RCW'(1);
      if (rn >= h) begin
        rn = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q  <= '0;
      row_pos_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_pos_q <= CPW'(cn);
        row_pos_q <= RPW'(rn);
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cell_q   <= cell_alive_i;
      s1_addr_q   <= CPW'(c);
      s1_qr_q     <= PosW'(qr);
      s1_qc_q     <= PosW'(qc);
      s1_border_q <= border;
      s1_fend_q   <= fend;
    end
  end

  lgs_row_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (CPW)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (CPW'(c)),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({s1_cell_q, rd_data[1]}),
    .busy_o    (mem_busy)
  );

  always_comb begin
    window_d = {window_q[5:0], s1_cell_q, rd_data[1], rd_data[0]};
    count    = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        count = count + 4'(window_d[i]);
      end
    end
    if (s1_border_q) begin
      alive = 1'b0;
    end else if (window_d[4]) begin
      alive = (count == 4'd2) || (count == 4'd3);
    end else begin
      alive = (count == 4'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        window_q    <= window_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_alive_q <= alive;
      out_row_q   <= s1_qr_q;
      out_col_q   <= s1_qc_q;
      out_fend_q  <= s1_fend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = out_alive_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_end_o  = out_fend_q;

endmodule

[tb/life_generation_stencil_tb.sv]
`timescale 1ns / 1ps

module life_generation_stencil_tb;
  import lgs_pkg::*;

  localparam int MaxWidth  = DefMaxWidth;
  localparam int MaxHeight = DefMaxHeight;

  typedef struct packed {
    logic alive;
    logic start;
  } cell_req_t;

  typedef struct packed {
    logic            alive;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            last;
  } cell_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               cell_alive_i = 1'b0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               next_alive_o;
  logic [PosW-1:0]    out_row_o;
  logic [PosW-1:0]    out_col_o;
  logic               frame_end_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_GRID_WIDTH;
  logic [CfgW-1:0]    cfg_data_i = '0;

  cell_req_t cell_stream_q[$];
  cell_res_t next_gen_q[$];

  logic [CfgW-1:0] width_reg = GridWidthRst;
  logic [CfgW-1:0] height_reg = GridHeightRst;
  bit              older_row[MaxWidth];
  bit              prev_row[MaxWidth];
  logic [8:0]      window = '0;
  int unsigned     col_pos = 0;
  int unsigned     row_pos = 0;

  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          rx_hold_armed = 1'b0;
  bit          rx_hold_done = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned queued = 0;

  life_generation_stencil i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_alive_i  (cell_alive_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .next_alive_o  (next_alive_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_end_o   (frame_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned used_size(logic [CfgW-1:0] v, int unsigned hi);
    if (v < MinSize) return MinSize;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void advance_generation(cell_req_t req);
    int unsigned w, h, c, r, qc, qr, nbrs;
    cell_res_t   res;
    w = used_size(width_reg, MaxWidth);
    h = used_size(height_reg, MaxHeight);
    if (req.start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    window = {window[5:0], req.alive, prev_row[c], older_row[c]};
    older_row[c] = prev_row[c];
    prev_row[c] = req.alive;
    if (c >= 1) begin
      qc = c - 1;
      qr = (r >= 1) ? r - 1 : h - 1;
    end else begin
      qc = w - 1;
      qr = (r >= 2) ? r - 2 : r + h - 2;
    end
    nbrs = $countones(window) - window[4];
    res.alive = 1'b0;
    if (qr != 0 && qr != h - 1 && qc != 0 && qc != w - 1) begin
      res.alive = window[4] ? (nbrs == 2 || nbrs == 3) : (nbrs == 3);
    end
    res.row = PosW'(qr);
    res.col = PosW'(qc);
    res.last = (qr == h - 2 && qc == w - 2);
    next_gen_q.push_back(res);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_generation(cell_req_t'({cell_alive_i, frame_start_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (cell_stream_q.size() != 0 && (tx_calm || $urandom_range(0, 99) >= 19)) begin
          nxt = cell_stream_q.pop_front();
          in_valid_i <= 1'b1;
          cell_alive_i <= nxt.alive;
          frame_start_i <= nxt.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [PosW-1:0] want, logic [PosW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (next_gen_q.size() == 0) begin
          $display("%0t: unexpected result alive=%0b row=%0d col=%0d end=%0b", $time,
                   next_alive_o, out_row_o, out_col_o, frame_end_o);
          mismatches++;
        end else begin
          want = next_gen_q.pop_front();
          check_field("next_alive", want.alive, next_alive_o);
          check_field("out_row", want.row, out_row_o);
          check_field("out_col", want.col, out_col_o);
          check_field("frame_end", want.last, frame_end_o);
        end
      end
      // The long hold-off lets the block fill up and push back on its input.
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (rx_hold_armed && !rx_hold_done && out_valid_o) begin
        rx_hold_done <= 1'b1;
        rx_hold_left <= 200;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rx_calm || $urandom_range(0, 99) >= 19;
      end
    end
  end

  task automatic set_grid(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GRID_WIDTH;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_reg = w;
    cfg_index_i <= CFG_GRID_HEIGHT;
    cfg_data_i <= h;
    do @(posedge clk_i); while (!cfg_ready_o);
    height_reg = h;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (cell_stream_q.size() != 0 || in_valid_i || next_gen_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_cells(int unsigned n, int unsigned density, bit marked, bit noisy);
    cell_req_t req;
    for (int unsigned i = 0; i < n; i++) begin
      req.alive = $urandom_range(0, 99) < density;
      req.start = (i == 0) ? marked : (noisy && $urandom_range(0, 199) == 0);
      cell_stream_q.push_back(req);
      queued++;
    end
  endtask

  function automatic logic [CfgW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return CfgW'($urandom_range(0, 1023));
      1: return CfgW'($urandom_range(0, 3));
      2: return CfgW'($urandom_range(MaxWidth - 2, MaxWidth + 2));
      3: return '1;
      default: return CfgW'($urandom_range(3, 14));
    endcase
  endfunction

  initial begin
    int unsigned frames, fsize, n;
    bit          marked;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default size: the first results wrap back into the previous frame.
    queue_cells(1, 100, 1'b1, 1'b0);
    queue_cells(1, 0, 1'b0, 1'b0);
    drain();
    // Smallest grid, one interior cell, all alive and then all dead.
    set_grid(CfgW'(3), CfgW'(3));
    queue_cells(9, 100, 1'b1, 1'b0);
    queue_cells(3, 0, 1'b1, 1'b0);
    drain();
    // Shrinking the width mid-row pushes the position past the new row end.
    set_grid(CfgW'(12), CfgW'(5));
    queue_cells(8, 50, 1'b1, 1'b0);
    drain();
    set_grid(CfgW'(2), '1);
    queue_cells(4, 50, 1'b0, 1'b0);
    drain();

    tx_calm = 1'b1;
    rx_calm = 1'b1;
    set_grid(CfgW'(10), CfgW'(8));
    repeat (2) queue_cells(80, 35, 1'b1, 1'b0);
    drain();
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    set_grid(CfgW'(16), CfgW'(6));
    rx_hold_armed = 1'b1;
    repeat (3) queue_cells(96, 40, 1'b1, 1'b1);
    drain();

    while (queued < 1850) begin
      set_grid(pick_size(), pick_size());
      fsize = used_size(width_reg, MaxWidth) * used_size(height_reg, MaxHeight);
      frames = $urandom_range(1, 3);
      marked = $urandom_range(0, 9) != 0;
      repeat (frames) begin
        n = fsize;
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, fsize + 5);
        if (n > 160) n = 160;
        queue_cells(n, $urandom_range(15, 60), marked, 1'b1);
        marked = 1'b1;
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && next_gen_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/lgs_pkg.sv
rtl/lgs_row_mem.sv
rtl/life_generation_stencil.sv
tb/life_generation_stencil_tb.sv
